/* rtl/plc_pkg.sv */
// Shared widths, register indexes and control types for the calibration block.
// No dependencies; imported by every module of the block.
package plc_pkg;

  // Field widths
  localparam int VALUE_W   = 32;  // signed Q16.16 sample, x, y and result
  localparam int POINT_W   = 64;  // one point register: y in 63:32, x in 31:0
  localparam int COUNT_W   = 3;   // point_count register
  localparam int CFG_IDX_W = 3;   // configuration register index

  // Divider iteration counter: one quotient bit per step
  localparam int DIV_CNT_W = $clog2(VALUE_W);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(VALUE_W - 1);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_0     = 3'd1;

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // capture sample, restart the point scan
    logic scan;      // fold the current point into the bracket search
    logic mult;      // register product, span and sign
    logic div_load;  // seed the divider from the product
    logic div_step;  // one restoring division step
    logic emit;      // write the output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic few_points;  // fewer than two points in use
    logic scan_last;   // current point is the last one in use
    logic clamp;       // sample lies outside the open x range
    logic out_free;    // output register can take a result this cycle
  } sts_t;

endpackage

/* rtl/plc_cfg_regs.sv */
// Configuration register file: point count and the (x, y) point registers.
// Depends on plc_pkg.
module plc_cfg_regs
  import plc_pkg::*;
#(
  parameter int MAX_POINTS = 6
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [CFG_IDX_W-1:0]               cfg_index,
  input  logic [POINT_W-1:0]                 cfg_data,
  output logic [COUNT_W-1:0]                 point_count,
  output logic [MAX_POINTS-1:0][POINT_W-1:0] points
);

  // Writes are always taken
  assign cfg_ready = 1'b1;

  // Decode the index; drop writes beyond the register list
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= '0;
      points      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_POINT_COUNT) begin
        point_count <= cfg_data[COUNT_W-1:0];
      end
      for (int k = 0; k < MAX_POINTS; k++) begin
        if (cfg_index == CFG_IDX_W'(int'(REG_POINT_0) + k)) begin
          points[k] <= cfg_data;
        end
      end
    end
  end

endmodule

/* rtl/plc_ctrl.sv */
// Controller: sequences scan, multiply, divide and result hand-off.
// Depends on plc_pkg.
module plc_ctrl
  import plc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic sample_valid,
  output logic sample_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_DLOAD = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  logic [2:0]           state;
  logic [2:0]           state_next;
  logic [DIV_CNT_W-1:0] div_cnt;

  // Take a new transaction only between items
  assign sample_stall = (state != ST_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (sample_valid) begin
          cmd.load   = 1'b1;
          state_next = sts.few_points ? ST_EMIT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mult   = 1'b1;
        state_next = sts.clamp ? ST_EMIT : ST_DLOAD;
      end
      ST_DLOAD: begin
        cmd.div_load = 1'b1;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (div_cnt == DIV_LAST) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Count divider steps
  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.div_load) begin
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + 1'b1;
    end
  end

endmodule

/* rtl/plc_dpath.sv */
// Datapath: bracket search over the points, 32x32 multiply, restoring divider
// and the output register. Depends on plc_pkg.
module plc_dpath
  import plc_pkg::*;
#(
  parameter int MAX_POINTS = 6
) (
  input  logic                               clk,
  input  logic                               rst,
  input  cmd_t                               cmd,
  output sts_t                               sts,
  input  logic [COUNT_W-1:0]                 point_count,
  input  logic [MAX_POINTS-1:0][POINT_W-1:0] points,
  input  logic signed [VALUE_W-1:0]          sample_value,
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic signed [VALUE_W-1:0]          calibrated_value
);

  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int IDX_W = $clog2(MAX_POINTS);

  logic [CNT_W-1:0]          n_eff;
  logic [CNT_W-1:0]          scan_idx;
  logic [POINT_W-1:0]        pt;
  logic signed [VALUE_W-1:0] pt_x;
  logic signed [VALUE_W-1:0] pt_y;

  logic signed [VALUE_W-1:0] smp;
  logic signed [VALUE_W-1:0] min_x, min_y, max_x, max_y;
  logic signed [VALUE_W-1:0] lo_x, lo_y, hi_x, hi_y;
  logic                      lo_ok, hi_ok;

  logic                      clamp_lo, clamp_hi;
  logic [VALUE_W:0]          dx_full, span_full, dy_full, mag_full;
  logic                      neg;

  logic [2*VALUE_W-1:0]      prod;
  logic [VALUE_W-1:0]        span_r;
  logic                      neg_r;
  logic [VALUE_W-1:0]        rem;
  logic [VALUE_W-1:0]        acc;
  logic [VALUE_W:0]          trial;
  logic [VALUE_W:0]          trial_diff;

  logic signed [VALUE_W-1:0] result;

  // Points in use, saturated to the table size
  always_comb begin
    if (point_count > COUNT_W'(MAX_POINTS)) begin
      n_eff = CNT_W'(MAX_POINTS);
    end else begin
      n_eff = CNT_W'(point_count);
    end
  end

  assign pt   = points[scan_idx[IDX_W-1:0]];
  assign pt_x = pt[VALUE_W-1:0];
  assign pt_y = pt[POINT_W-1:VALUE_W];

  // Capture the sample and walk the points one per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      lo_ok    <= 1'b0;
      hi_ok    <= 1'b0;
    end else if (cmd.load) begin
      scan_idx <= '0;
      lo_ok    <= 1'b0;
      hi_ok    <= 1'b0;
    end else if (cmd.scan) begin
      scan_idx <= scan_idx + 1'b1;
      if (pt_x < smp && (!lo_ok || pt_x >= lo_x)) begin
        lo_ok <= 1'b1;
      end
      if (pt_x >= smp && (!hi_ok || pt_x < hi_x)) begin
        hi_ok <= 1'b1;
      end
    end
  end

  // Track the ends (lowest index on a tie at the bottom, highest at the top),
  // the largest x below the sample and the smallest x at or above it
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      smp <= sample_value;
    end
    if (cmd.scan) begin
      if (scan_idx == '0 || pt_x < min_x) begin
        min_x <= pt_x;
        min_y <= pt_y;
      end
      if (scan_idx == '0 || pt_x >= max_x) begin
        max_x <= pt_x;
        max_y <= pt_y;
      end
      if (pt_x < smp && (!lo_ok || pt_x >= lo_x)) begin
        lo_x <= pt_x;
        lo_y <= pt_y;
      end
      if (pt_x >= smp && (!hi_ok || pt_x < hi_x)) begin
        hi_x <= pt_x;
        hi_y <= pt_y;
      end
    end
  end

  assign clamp_lo = (smp <= min_x);
  assign clamp_hi = (smp >= max_x);

  // Segment offsets; both differences are positive inside the range
  always_comb begin
    dx_full   = {smp[VALUE_W-1], smp} - {lo_x[VALUE_W-1], lo_x};
    span_full = {hi_x[VALUE_W-1], hi_x} - {lo_x[VALUE_W-1], lo_x};
    dy_full   = {hi_y[VALUE_W-1], hi_y} - {lo_y[VALUE_W-1], lo_y};
    neg       = dy_full[VALUE_W];
    mag_full  = neg ? ((VALUE_W+1)'(0) - dy_full) : dy_full;
  end

  // Register the product of offset and rise
  always_ff @(posedge clk) begin
    if (cmd.mult) begin
      prod   <= (2*VALUE_W)'(dx_full[VALUE_W-1:0]) * (2*VALUE_W)'(mag_full[VALUE_W-1:0]);
      span_r <= span_full[VALUE_W-1:0];
      neg_r  <= neg;
    end
  end

  // Restoring division, one quotient bit per cycle; the quotient fits
  // 32 bits, so the upper product half seeds the remainder
  assign trial      = {rem, acc[VALUE_W-1]};
  assign trial_diff = trial - {1'b0, span_r};

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem <= prod[2*VALUE_W-1:VALUE_W];
      acc <= prod[VALUE_W-1:0];
    end else if (cmd.div_step) begin
      rem <= trial_diff[VALUE_W] ? trial[VALUE_W-1:0] : trial_diff[VALUE_W-1:0];
      acc <= {acc[VALUE_W-2:0], ~trial_diff[VALUE_W]};
    end
  end

  // Pick pass-through, single point, end clamp or interpolated value
  always_comb begin
    if (n_eff == '0) begin
      result = smp;
    end else if (n_eff == CNT_W'(1)) begin
      result = points[0][POINT_W-1:VALUE_W];
    end else if (clamp_lo) begin
      result = min_y;
    end else if (clamp_hi) begin
      result = max_y;
    end else if (neg_r) begin
      result = lo_y - acc;
    end else begin
      result = lo_y + acc;
    end
  end

  // Output register; hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      calibrated_value <= result;
    end
  end

  // Status to the controller
  always_comb begin
    sts.few_points = (n_eff < CNT_W'(2));
    sts.scan_last  = (scan_idx == n_eff - 1'b1);
    sts.clamp      = clamp_lo | clamp_hi;
    sts.out_free   = !result_valid || !result_stall;
  end

endmodule

/* rtl/piecewise_linear_calibration.sv */
// Top level of the piecewise linear calibration block: config registers,
// controller and datapath. Depends on plc_pkg, plc_cfg_regs, plc_ctrl, plc_dpath.
//
//   Channel  Direction  Handshake               Payload
//   -------  ---------  ----------------------  ------------------------------
//   cfg      in         cfg_valid / cfg_ready   cfg_index[2:0], cfg_data[63:0]
//   sample   in         sample_valid / stall    sample_value (signed Q16.16)
//   result   out        result_valid / stall    calibrated_value (signed Q16.16)
//
// An item goes from load straight to emit with fewer than two points; one that
// clamps to an end passes the point scan and the multiply, and one that
// interpolates adds the divider load and the restoring division, one bit per cycle.
// The points are walked one per cycle. Reset (synchronous) clears the config
// registers to zero and empties the output. A new sample is taken while a
// result still waits in the output register; a stalled output holds the
// finished next result in the datapath until the output register frees.
module piecewise_linear_calibration
  import plc_pkg::*;
#(
  parameter int MAX_POINTS = 6
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [POINT_W-1:0]        cfg_data,
  input  logic                      sample_valid,
  output logic                      sample_stall,
  input  logic signed [VALUE_W-1:0] sample_value,
  output logic                      result_valid,
  input  logic                      result_stall,
  output logic signed [VALUE_W-1:0] calibrated_value
);

  logic [COUNT_W-1:0]                 point_count;
  logic [MAX_POINTS-1:0][POINT_W-1:0] points;
  cmd_t                               cmd;
  sts_t                               sts;

  plc_cfg_regs #(
    .MAX_POINTS (MAX_POINTS)
  ) u_cfg_regs (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .point_count (point_count),
    .points      (points)
  );

  plc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  plc_dpath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dpath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .point_count      (point_count),
    .points           (points),
    .sample_value     (sample_value),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .calibrated_value (calibrated_value)
  );

endmodule

/* rtl/plc_checker.sv */
// Port-level checks for the calibration block, bound to the top level.
// Depends on plc_pkg for the value width.
module plc_checker
  import plc_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      sample_valid,
  input logic                      sample_stall,
  input logic                      result_valid,
  input logic                      result_stall,
  input logic signed [VALUE_W-1:0] calibrated_value
);

  logic       in_xact;
  logic       out_xact;
  logic [2:0] pending;

  assign in_xact  = sample_valid && !sample_stall;
  assign out_xact = result_valid && !result_stall;

  // Count transactions taken but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + {2'b00, in_xact} - {2'b00, out_xact};
    end
  end

  // Hold a stalled result
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(calibrated_value))
    else $error("stalled result dropped or changed");

  // Every result belongs to a taken sample
  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> pending != 3'd0)
    else $error("result without an outstanding sample");

  // One item in work and one waiting is the limit
  a_full_stalls: assert property (@(posedge clk) disable iff (rst)
    pending == 3'd2 |-> sample_stall)
    else $error("sample taken with output and work both occupied");

  // No result can appear the cycle after a sample is taken
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> !$past(in_xact))
    else $error("result faster than the minimum latency");

endmodule

bind piecewise_linear_calibration plc_checker u_checker (.*);

/* bench/piecewise_linear_calibration_tb.sv */
// Self-checking bench for piecewise_linear_calibration: directed and random
// tables and samples, checked against a local calibration predictor.
// Depends on plc_pkg and the piecewise_linear_calibration RTL.
module piecewise_linear_calibration_tb;
  import plc_pkg::*;

  localparam int CLK_PERIOD   = 8;
  localparam int TABLE_SIZE   = 6;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 50;
  localparam int SETTLE_CYCLES = 48;
  localparam int CYCLE_LIMIT  = 400000;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic [VALUE_W-1:0]   VALUE_MIN  = 32'h8000_0000;
  localparam logic [VALUE_W-1:0]   VALUE_MAX  = 32'h7fff_ffff;
  localparam logic [VALUE_W-1:0]   ONE_Q16    = 32'h0001_0000;

  logic                      clk;
  logic                      rst;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [POINT_W-1:0]        cfg_data;
  logic                      sample_valid;
  logic                      sample_stall;
  logic signed [VALUE_W-1:0] sample_value;
  logic                      result_valid;
  logic                      result_stall;
  logic signed [VALUE_W-1:0] calibrated_value;

  // Local copy of the calibration table
  logic [COUNT_W-1:0] table_count;
  logic [POINT_W-1:0] table_points [TABLE_SIZE];

  logic [VALUE_W-1:0] calibrated_q [$];

  int  samples_sent;
  int  results_seen;
  int  mismatches;
  int  tables_loaded;
  int  cycle_count;
  bit  sender_steady;
  bit  stall_steady;

  piecewise_linear_calibration #(
    .MAX_POINTS(TABLE_SIZE)
  ) u_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .sample_valid    (sample_valid),
    .sample_stall    (sample_stall),
    .sample_value    (sample_value),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .calibrated_value(calibrated_value)
  );

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still outstanding",
               cycle_count, calibrated_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                         logic [POINT_W-1:0] data);
    int slot;
    slot = int'(idx) - int'(REG_POINT_0);
    if (idx == REG_POINT_COUNT) begin
      table_count = data[COUNT_W-1:0];
    end else if (slot >= 0 && slot < TABLE_SIZE) begin
      table_points[slot] = data;
    end
  endfunction

  function automatic longint point_x(int k);
    return longint'($signed(table_points[k][VALUE_W-1:0]));
  endfunction

  function automatic longint point_y(int k);
    return longint'($signed(table_points[k][POINT_W-1:VALUE_W]));
  endfunction

  // Saturate the count at the table size
  function automatic int points_in_use();
    int n;
    n = int'(table_count);
    if (n > TABLE_SIZE) n = TABLE_SIZE;
    return n;
  endfunction

  function automatic logic [VALUE_W-1:0] calibrate(logic signed [VALUE_W-1:0] sample);
    int n, i, j;
    int ord [TABLE_SIZE];
    longint v, x_lo, x_hi, y_lo, y_hi, r;
    longint unsigned span, dx, mag, q;
    bit descending;
    v = longint'(sample);
    n = points_in_use();
    if (n == 0) return sample;
    if (n == 1) return VALUE_W'(point_y(0));
    // Stable insertion sort on x: equal x keep register order
    for (i = 0; i < n; i++) begin
      j = i;
      while (j > 0 && point_x(ord[j - 1]) > point_x(i)) begin
        ord[j] = ord[j - 1];
        j--;
      end
      ord[j] = i;
    end
    // Clamp at both ends
    if (v <= point_x(ord[0])) return VALUE_W'(point_y(ord[0]));
    if (v >= point_x(ord[n - 1])) return VALUE_W'(point_y(ord[n - 1]));
    // Interpolate in the first bracketing segment, truncating toward zero
    for (i = 0; i + 1 < n; i++) begin
      x_lo = point_x(ord[i]);
      x_hi = point_x(ord[i + 1]);
      if (v >= x_lo && v <= x_hi) begin
        y_lo = point_y(ord[i]);
        y_hi = point_y(ord[i + 1]);
        span = unsigned'(x_hi - x_lo);
        dx = unsigned'(v - x_lo);
        if (span == 0) return VALUE_W'(y_lo);
        descending = y_hi < y_lo;
        mag = descending ? unsigned'(y_lo - y_hi) : unsigned'(y_hi - y_lo);
        q = (dx * mag) / span;
        r = descending ? y_lo - longint'(q) : y_lo + longint'(q);
        return VALUE_W'(r);
      end
    end
    return '0;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Mostly short gaps, now and then a long one
  function automatic int idle_length(bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [POINT_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    apply_register(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic write_point(int k, logic [VALUE_W-1:0] x, logic [VALUE_W-1:0] y);
    write_register(CFG_IDX_W'(int'(REG_POINT_0) + k), {y, x});
  endtask

  // Send one sample transaction and queue its expected result
  task automatic send_sample(logic [VALUE_W-1:0] value);
    int gap;
    gap = idle_length(sender_steady);
    @(negedge clk);
    if (gap > 0) begin
      sample_valid = 1'b0;
      sample_value = $urandom;
      repeat (gap) @(negedge clk);
    end
    sample_valid = 1'b1;
    sample_value = value;
    do @(posedge clk); while (sample_stall);
    calibrated_q.insert(calibrated_q.size(), calibrate(value));
    samples_sent++;
  endtask

  // Hold the sender until every outstanding result has come back
  task automatic drain_results();
    @(negedge clk);
    sample_valid = 1'b0;
    while (calibrated_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Samples biased toward the table's x range and its breakpoints
  function automatic logic [VALUE_W-1:0] pick_sample();
    int n, k, r;
    longint lo, hi;
    longint unsigned width;
    n = points_in_use();
    r = $urandom_range(0, 99);
    if (n < 2 || r < 15) return $urandom;
    if (r < 22) return (r % 2 == 0) ? VALUE_MIN : VALUE_MAX;
    k = $urandom_range(0, n - 1);
    if (r < 40) return VALUE_W'(point_x(k) + longint'($urandom_range(0, 2)) - 1);
    lo = point_x(0);
    hi = point_x(0);
    for (k = 1; k < n; k++) begin
      if (point_x(k) < lo) lo = point_x(k);
      if (point_x(k) > hi) hi = point_x(k);
    end
    width = unsigned'(hi - lo) + 1;
    return VALUE_W'(lo + longint'({$urandom, $urandom} % width));
  endfunction

  task automatic load_random_table(int phase);
    int k, style;
    logic [VALUE_W-1:0] base, x, y, last_x;
    if (phase == 0) write_register(REG_POINT_COUNT, POINT_W'(TABLE_SIZE));
    else if (phase == PHASES - 1) write_register(REG_POINT_COUNT, POINT_W'(7));
    else write_register(REG_POINT_COUNT, POINT_W'($urandom_range(0, 7)));
    style = (phase == 0) ? 0 : $urandom_range(0, 2);
    base = $urandom;
    last_x = base;
    for (k = 0; k < TABLE_SIZE; k++) begin
      case (style)
        0: begin
          x = $urandom;
          y = $urandom;
        end
        1: begin
          x = base + VALUE_W'($urandom_range(0, 1 << 20));
          y = $urandom;
        end
        default: begin
          x = VALUE_W'(($urandom_range(0, 20) - 10) * 65536);
          y = VALUE_W'(($urandom_range(0, 200) - 100) * 65536 + $urandom_range(0, 65535));
        end
      endcase
      // Repeat an x now and then to build ties
      if (k > 0 && $urandom_range(0, 3) == 0) x = last_x;
      last_x = x;
      write_point(k, x, y);
    end
    tables_loaded++;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Empty table: the sample passes through unchanged
  task automatic test_pass_through();
    write_register(REG_POINT_COUNT, '0);
    send_sample(VALUE_MIN);
    send_sample(VALUE_MAX);
    send_sample('0);
    send_sample('1);
    send_sample(32'h5555_5555);
    send_sample(32'haaaa_aaaa);
    drain_results();
    tables_loaded++;
  endtask

  // One point: its y for every sample
  task automatic test_single_point();
    write_point(0, 32'h0001_8000, VALUE_MIN);
    write_register(REG_POINT_COUNT, POINT_W'(1));
    send_sample(VALUE_MIN);
    send_sample(VALUE_MAX);
    send_sample(32'h0001_8000);
    drain_results();
    tables_loaded++;
  endtask

  // Full-range segment with a falling slope, points given out of order
  task automatic test_extreme_span();
    write_point(0, VALUE_MAX, VALUE_MIN);
    write_point(1, VALUE_MIN, VALUE_MAX);
    write_register(REG_POINT_COUNT, POINT_W'(2));
    send_sample('0);
    send_sample(VALUE_MIN + 1);
    send_sample(VALUE_MAX - 1);
    send_sample(VALUE_MIN);
    send_sample(VALUE_MAX);
    drain_results();
    tables_loaded++;
  endtask

  // Tied x at both ends and in the middle, count above the table size,
  // and a write to an index past the last register
  task automatic test_ties_and_order();
    write_point(0, 3 * ONE_Q16, 32'd10);
    write_point(1, ONE_Q16, 32'd20);
    write_point(2, ONE_Q16, 32'd30);
    write_point(3, 3 * ONE_Q16, 32'd40);
    write_point(4, 2 * ONE_Q16, -32'sd50000);
    write_point(5, 2 * ONE_Q16, 32'd60);
    write_register(REG_POINT_COUNT, POINT_W'(7));
    send_sample(ONE_Q16);
    send_sample('0);
    send_sample(32'h0001_8000);
    send_sample(2 * ONE_Q16);
    send_sample(32'h0002_8000);
    send_sample(3 * ONE_Q16);
    send_sample(VALUE_MAX);
    drain_results();
    write_register(REG_UNUSED, {$urandom, $urandom});
    send_sample(32'h0002_8000);
    drain_results();
    tables_loaded++;
  endtask

  // Random tables, each with a run of biased random samples
  task automatic test_random_tables();
    int phase, item;
    for (phase = 0; phase < PHASES; phase++) begin
      load_random_table(phase);
      sender_steady = (phase % 4 == 1);
      stall_steady  = (phase % 4 == 2);
      for (item = 0; item < PHASE_ITEMS; item++) begin
        if (phase == 3 && item == PHASE_ITEMS / 2) drain_results();
        send_sample(pick_sample());
      end
      drain_results();
    end
    sender_steady = 1'b0;
    stall_steady  = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Random back-pressure: open stretches then stalls of random length
  initial begin : drive_stall
    int open_len, hold_len;
    result_stall = 1'b0;
    forever begin
      open_len = $urandom_range(1, 12);
      @(negedge clk);
      result_stall = 1'b0;
      repeat (open_len - 1) @(negedge clk);
      hold_len = idle_length(stall_steady);
      if (hold_len > 0) begin
        @(negedge clk);
        result_stall = 1'b1;
        repeat (hold_len - 1) @(negedge clk);
      end
    end
  end

  // Compare each result transaction with the oldest prediction
  always @(posedge clk) begin : check_results
    logic [VALUE_W-1:0] want;
    if (!rst && result_valid && !result_stall) begin
      results_seen++;
      if (calibrated_q.size() == 0) begin
        $error("calibrated_value: no result expected, actual %h", calibrated_value);
        mismatches++;
      end else begin
        want = calibrated_q.pop_front();
        if (calibrated_value !== want) begin
          $error("calibrated_value: expected %h, actual %h", want, calibrated_value);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin : run_tests
    int k;
    rst           = 1'b1;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    sample_valid  = 1'b0;
    sample_value  = '0;
    table_count   = '0;
    for (k = 0; k < TABLE_SIZE; k++) table_points[k] = '0;
    samples_sent  = 0;
    results_seen  = 0;
    mismatches    = 0;
    tables_loaded = 0;
    cycle_count   = 0;
    sender_steady = 1'b0;
    stall_steady  = 1'b0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_pass_through();
    test_single_point();
    test_extreme_span();
    test_ties_and_order();
    test_random_tables();
    drain_results();

    if (calibrated_q.size() != 0) begin
      $error("calibrated_value: %0d results never arrived", calibrated_q.size());
      mismatches++;
    end
    $display("Ran %0d samples over %0d table settings (empty, single, tied, full range).",
             samples_sent, tables_loaded);
    $display("Compared %0d results, %0d mismatches.", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
